// ===== rtl/core/joystick_rotation_step_detector_assert.svh =====
// Assertion macros for the joystick rotation step detector.
// Each macro expects signals named clk and rst in the calling scope.
`ifndef JOYSTICK_ROTATION_STEP_DETECTOR_ASSERT_SVH
`define JOYSTICK_ROTATION_STEP_DETECTOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define JRSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define JRSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/jrsd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and codes for the joystick rotation step detector.
// No dependencies.
package jrsd_pkg;

  localparam int TIME_W     = 32;
  localparam int RADIUS_W   = 12;
  localparam int ANGLE_W    = 16;
  localparam int INTERVAL_W = 20;
  localparam int STEP_W     = 2;
  localparam int CFG_IDX_W  = 2;

  localparam int BINS_DEFAULT = 16;

  localparam logic [RADIUS_W-1:0]   EXTEND_THR_RESET  = 12'd2867;
  localparam logic [RADIUS_W-1:0]   RETRACT_THR_RESET = 12'd1638;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET    = 20'd10000;

  // Step codes: one sector up reads -1, one sector down reads +1.
  localparam logic signed [STEP_W-1:0] STEP_NONE = 2'sb00;
  localparam logic signed [STEP_W-1:0] STEP_DOWN = 2'sb01;
  localparam logic signed [STEP_W-1:0] STEP_UP   = 2'sb11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXTEND_THR      = 2'd0,
    REG_RETRACT_THR     = 2'd1,
    REG_SAMPLE_INTERVAL = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [RADIUS_W-1:0]   extend_threshold;
    logic [RADIUS_W-1:0]   retract_threshold;
    logic [INTERVAL_W-1:0] sample_interval_us;
  } jrsd_cfg_t;

  typedef struct packed {
    logic signed [STEP_W-1:0] rotation_step;
    logic                     is_extended;
  } jrsd_step_t;

endpackage

// ===== rtl/core/jrsd_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: one joystick reading per word.
// Depends on jrsd_pkg.
interface jrsd_in_if import jrsd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [TIME_W-1:0]          now_us;
  logic [RADIUS_W-1:0]        radius;
  logic signed [ANGLE_W-1:0]  angle;

  modport source (output valid, now_us, radius, angle, input ready);
  modport sink   (input valid, now_us, radius, angle, output ready);
endinterface

// ===== rtl/core/jrsd_out_if.sv =====
`timescale 1ns / 1ps
// Result channel: one rotation step word per reading.
// Depends on jrsd_pkg.
interface jrsd_out_if import jrsd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [STEP_W-1:0]  rotation_step;
  logic                      is_extended;

  modport source (output valid, rotation_step, is_extended, input ready);
  modport sink   (input valid, rotation_step, is_extended, output ready);
endinterface

// ===== rtl/core/jrsd_cfg_if.sv =====
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
// Depends on jrsd_pkg.
interface jrsd_cfg_if import jrsd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [INTERVAL_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/joystick_rotation_step_detector.sv =====
`timescale 1ns / 1ps
// Joystick rotation step detector: turns polar stick readings into encoder steps.
// Depends on jrsd_pkg, the channel interfaces, jrsd_cfg_regs, jrsd_sector,
// jrsd_tracker and the assertion macro header.
//
// Usage:
//   sample : valid/ready input; each word holds now_us, radius and angle.
//   result : valid/ready output; exactly one word per sample word, in order,
//            with rotation_step (-1 sector up, +1 sector down, 0 otherwise)
//            and is_extended.
//   cfg    : valid/ready register writes (0 extend threshold, 1 retract
//            threshold, 2 sample interval); always ready, index 3 ignored.
//            Write only while no sample word is in flight.
//   Throughput: one word per cycle while result is not stalled; the input
//   register and the result register each hold one word, in that order, and
//   the state update (time gate, hysteresis, sector compare) is a single
//   combinational pass between them.
//   A stalled receiver holds the result word; one more sample is taken into
//   the input register, then sample.ready drops until result drains.
//   Reset: synchronous; restores register defaults, clears the extended
//   flag, last sector and last sample time, and empties both registers.
module joystick_rotation_step_detector import jrsd_pkg::*; #(
  parameter int BINS = BINS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  jrsd_in_if.sink   sample,
  jrsd_out_if.source result,
  jrsd_cfg_if.sink  cfg
);

  localparam int SEC_W = $clog2(BINS);

  jrsd_cfg_t                 regs;
  jrsd_step_t                step_word;
  logic [SEC_W-1:0]          sector;

  logic                      in_valid;
  logic [TIME_W-1:0]         in_now;
  logic [RADIUS_W-1:0]       in_radius;
  logic signed [ANGLE_W-1:0] in_angle;

  logic                      fire;
  logic                      take;

  logic                      step_flag_ok;
  logic                      step_code_ok;

  jrsd_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  jrsd_sector #(.BINS(BINS)) u_sector (
    .angle  (in_angle),
    .sector (sector)
  );

  jrsd_tracker #(.BINS(BINS)) u_tracker (
    .clk    (clk),
    .rst    (rst),
    .regs   (regs),
    .fire   (fire),
    .now_us (in_now),
    .radius (in_radius),
    .sector (sector),
    .result (step_word)
  );

  // Advance the held word whenever the result register is free or draining.
  assign fire         = in_valid && (!result.valid || result.ready);
  assign sample.ready = !in_valid || fire;
  assign take         = sample.valid && sample.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_now    <= sample.now_us;
      in_radius <= sample.radius;
      in_angle  <= sample.angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (fire) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.rotation_step <= step_word.rotation_step;
      result.is_extended   <= step_word.is_extended;
    end
  end

  assign step_flag_ok = (result.rotation_step == STEP_NONE) || result.is_extended;
  assign step_code_ok = (result.rotation_step == STEP_NONE) ||
                        (result.rotation_step == STEP_UP) ||
                        (result.rotation_step == STEP_DOWN);

  `include "joystick_rotation_step_detector_assert.svh"

  `JRSD_ASSERT_NEXT(a_held_word_kept, in_valid && !fire, in_valid, "held sample word lost")
  `JRSD_ASSERT_NEXT(a_fire_loads_result, fire, result.valid, "advanced word did not reach result")
  `JRSD_ASSERT_NOW(a_empty_takes_input, !in_valid, sample.ready, "empty input register not ready")
  `JRSD_ASSERT_NOW(a_step_needs_extend, result.valid, step_flag_ok, "step while retracted")
  `JRSD_ASSERT_NOW(a_step_code_legal, result.valid, step_code_ok, "illegal step code")

endmodule

// ===== rtl/core/jrsd_cfg_regs.sv =====
`timescale 1ns / 1ps
// Configuration register file: thresholds and sample interval.
// Depends on jrsd_pkg and jrsd_cfg_if.
module jrsd_cfg_regs import jrsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  jrsd_cfg_if.sink   cfg,
  output jrsd_cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.extend_threshold   <= EXTEND_THR_RESET;
      regs.retract_threshold  <= RETRACT_THR_RESET;
      regs.sample_interval_us <= INTERVAL_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_EXTEND_THR:      regs.extend_threshold   <= cfg.data[RADIUS_W-1:0];
        REG_RETRACT_THR:     regs.retract_threshold  <= cfg.data[RADIUS_W-1:0];
        REG_SAMPLE_INTERVAL: regs.sample_interval_us <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/jrsd_sector.sv =====
`timescale 1ns / 1ps
// Angle quantizer: maps one full turn onto BINS equal sectors.
// Depends on jrsd_pkg.
module jrsd_sector import jrsd_pkg::*; #(
  parameter int BINS = BINS_DEFAULT,
  localparam int SEC_W = $clog2(BINS),
  localparam int PROD_W = ANGLE_W + SEC_W + 1
) (
  input  logic signed [ANGLE_W-1:0] angle,
  output logic [SEC_W-1:0]          sector
);

  logic [PROD_W-1:0] product;

  // Raw angle bits already read as 0..2pi; sector = floor(u * BINS / 2^16).
  assign product = PROD_W'($unsigned(angle)) * PROD_W'(BINS);
  assign sector  = product[ANGLE_W +: SEC_W];

endmodule

// ===== rtl/core/jrsd_tracker.sv =====
`timescale 1ns / 1ps
// Sample gate, extend hysteresis and sector tracking state.
// Depends on jrsd_pkg.
module jrsd_tracker import jrsd_pkg::*; #(
  parameter int BINS = BINS_DEFAULT,
  localparam int SEC_W = $clog2(BINS)
) (
  input  logic                clk,
  input  logic                rst,
  input  jrsd_cfg_t           regs,
  input  logic                fire,
  input  logic [TIME_W-1:0]   now_us,
  input  logic [RADIUS_W-1:0] radius,
  input  logic [SEC_W-1:0]    sector,
  output jrsd_step_t          result
);

  localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(BINS - 1);

  logic                extended;
  logic [SEC_W-1:0]    prev_sector;
  logic                prev_valid;
  logic [TIME_W-1:0]   last_time;

  logic                extended_next;
  logic [SEC_W-1:0]    prev_sector_next;
  logic                prev_valid_next;
  logic [TIME_W-1:0]   last_time_next;

  logic [TIME_W-1:0]   elapsed;
  logic                use_sample;
  logic                above;
  logic                below;
  logic                held_valid;
  logic [SEC_W-1:0]    sec_up;
  logic [SEC_W-1:0]    sec_down;
  logic signed [STEP_W-1:0] step;

  always_comb begin
    elapsed    = now_us - last_time;
    use_sample = elapsed > TIME_W'(regs.sample_interval_us);
    above      = radius > regs.extend_threshold;
    below      = radius < regs.retract_threshold;
    sec_up     = (prev_sector == SEC_LAST) ? '0 : prev_sector + 1'b1;
    sec_down   = (prev_sector == '0) ? SEC_LAST : prev_sector - 1'b1;

    extended_next    = extended;
    prev_sector_next = prev_sector;
    prev_valid_next  = prev_valid;
    last_time_next   = last_time;
    step             = STEP_NONE;

    if (use_sample) begin
      last_time_next = now_us;
      held_valid     = prev_valid;
      if (above) begin
        extended_next = 1'b1;
      end else if (below) begin
        extended_next = 1'b0;
        held_valid    = 1'b0;
      end
      prev_valid_next = held_valid;
      if (extended_next) begin
        if (held_valid && sector == sec_up) begin
          step = STEP_UP;
        end else if (held_valid && sector == sec_down) begin
          step = STEP_DOWN;
        end
        prev_sector_next = sector;
        prev_valid_next  = 1'b1;
      end
    end else begin
      held_valid = prev_valid;
    end

    result.rotation_step = step;
    result.is_extended   = extended_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      extended    <= 1'b0;
      prev_sector <= '0;
      prev_valid  <= 1'b0;
      last_time   <= '0;
    end else if (fire) begin
      extended    <= extended_next;
      prev_sector <= prev_sector_next;
      prev_valid  <= prev_valid_next;
      last_time   <= last_time_next;
    end
  end

endmodule
